// File: rtl/gdh_pkg.sv
// gdh_pkg: shared constants, codes and types of the grid distance heuristic core
// no dependencies; imported by every module under rtl

package gdh_pkg;

  // coordinate width and the widths that follow from it
  localparam int COORD_BITS = 10;
  localparam int SQ_W       = 2 * COORD_BITS;     // one squared difference
  localparam int SUM_W      = SQ_W + 1;           // dx^2 + dy^2
  localparam int ROOT_W     = COORD_BITS + 4;     // root of 100 * (dx^2 + dy^2)
  localparam int RAD_W      = 2 * ROOT_W;         // radicand and remainder
  localparam int RES_W      = COORD_BITS + 5;     // unsaturated distance
  localparam int DIST_W     = 15;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // distance_mode register codes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_MANHATTAN = 3'd0;
  localparam logic [MODE_W-1:0] MODE_EUCLIDEAN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OCTILE    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CHEBYSHEV = 3'd3;

  // operation carried from front to back
  typedef logic [2:0] op_t;
  localparam op_t OP_MANHATTAN = 3'd0;
  localparam op_t OP_EUCLIDEAN = 3'd1;
  localparam op_t OP_OCTILE    = 3'd2;
  localparam op_t OP_CHEBYSHEV = 3'd3;
  localparam op_t OP_ZERO      = 3'd4;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // accepting edge to the edge that samples done
  localparam int PIPE_LAT = ROOT_W + 5;

  typedef struct packed {
    op_t                   op;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
    logic [COORD_BITS-1:0] lo;
    logic [COORD_BITS-1:0] hi;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/gdh_front.sv
// gdh_front: classifies a point pair into an operation and its differences
// depends on gdh_pkg

module gdh_front
  import gdh_pkg::*;
(
  input  logic [MODE_W-1:0]     mode,
  input  logic [COORD_BITS-1:0] from_x,
  input  logic [COORD_BITS-1:0] from_y,
  input  logic [COORD_BITS-1:0] to_x,
  input  logic [COORD_BITS-1:0] to_y,
  output item_t                 item
);

  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;

  assign dx = (from_x > to_x) ? from_x - to_x : to_x - from_x;
  assign dy = (from_y > to_y) ? from_y - to_y : to_y - from_y;

  always_comb begin
    item.dx = dx;
    item.dy = dy;
    item.lo = (dx < dy) ? dx : dy;
    item.hi = (dx < dy) ? dy : dx;
    unique case (mode)
      MODE_MANHATTAN: item.op = OP_MANHATTAN;
      MODE_EUCLIDEAN: item.op = OP_EUCLIDEAN;
      MODE_OCTILE:    item.op = OP_OCTILE;
      MODE_CHEBYSHEV: item.op = OP_CHEBYSHEV;
      default:        item.op = OP_ZERO;   // unused modes give zero
    endcase
  end

endmodule

// File: rtl/gdh_queue.sv
// gdh_queue: short first-in first-out queue of classified items
// depends on gdh_pkg

module gdh_queue
  import gdh_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  item_t         push_item,
  input  logic          pop,
  output item_t         pop_item,
  output queue_status_t status
);

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item     = slots[rd_ptr];
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);

endmodule

// File: rtl/gdh_back.sv
// gdh_back: pipelined distance evaluation, squares, radicand, one root bit a stage
// depends on gdh_pkg

module gdh_back
  import gdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  item_t             in_item,
  output logic              done,
  output logic [DIST_W-1:0] distance
);

  localparam int CMP_W = RES_W + DIST_W;

  // stage a: squares and the straight-line metrics
  logic [RES_W-1:0] sum_xy;
  logic [RES_W-1:0] lin_a;
  logic             a_vld;
  logic             a_euc;
  logic [RES_W-1:0] a_lin;
  logic [SQ_W-1:0]  a_sqx;
  logic [SQ_W-1:0]  a_sqy;

  always_comb begin
    sum_xy = RES_W'(in_item.dx) + RES_W'(in_item.dy);
    unique case (in_item.op)
      OP_MANHATTAN: lin_a = (sum_xy << 3) + (sum_xy << 1);
      OP_OCTILE:    lin_a = (RES_W'(in_item.hi) << 3) + (RES_W'(in_item.hi) << 1)
                          + (RES_W'(in_item.lo) << 2);
      OP_CHEBYSHEV: lin_a = (RES_W'(in_item.hi) << 3) + (RES_W'(in_item.hi) << 1);
      default:      lin_a = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_euc <= (in_item.op == OP_EUCLIDEAN);
    a_lin <= lin_a;
    a_sqx <= SQ_W'(in_item.dx) * SQ_W'(in_item.dx);
    a_sqy <= SQ_W'(in_item.dy) * SQ_W'(in_item.dy);
  end

  // stage b: sum of squares
  logic             b_vld;
  logic             b_euc;
  logic [RES_W-1:0] b_lin;
  logic [SUM_W-1:0] b_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_euc <= a_euc;
    b_lin <= a_lin;
    b_sum <= SUM_W'(a_sqx) + SUM_W'(a_sqy);
  end

  // stage c and root stages: entry 0 holds the radicand 100 * sum
  logic             s_vld  [0:ROOT_W];
  logic             s_euc  [0:ROOT_W];
  logic [RES_W-1:0] s_lin  [0:ROOT_W];
  logic [RAD_W-1:0] s_rem  [0:ROOT_W];
  logic [RAD_W-1:0] s_root [0:ROOT_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld[0] <= 1'b0;
    end else begin
      s_vld[0] <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    s_euc[0]  <= b_euc;
    s_lin[0]  <= b_lin;
    s_rem[0]  <= (RAD_W'(b_sum) << 6) + (RAD_W'(b_sum) << 5) + (RAD_W'(b_sum) << 2);
    s_root[0] <= '0;
  end

  for (genvar i = 0; i < ROOT_W; i++) begin : g_root
    localparam int SH = 2 * (ROOT_W - 1 - i);

    logic [RAD_W-1:0] bit_val;
    logic [RAD_W:0]   trial;
    logic             take;

    assign bit_val = RAD_W'(1) << SH;
    assign trial   = {1'b0, s_root[i]} + {1'b0, bit_val};
    assign take    = ({1'b0, s_rem[i]} >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        s_vld[i+1] <= 1'b0;
      end else begin
        s_vld[i+1] <= s_vld[i];
      end
    end

    always_ff @(posedge clk) begin
      s_euc[i+1] <= s_euc[i];
      s_lin[i+1] <= s_lin[i];
      if (take) begin
        s_rem[i+1]  <= s_rem[i] - trial[RAD_W-1:0];
        s_root[i+1] <= (s_root[i] >> 1) + bit_val;
      end else begin
        s_rem[i+1]  <= s_rem[i];
        s_root[i+1] <= s_root[i] >> 1;
      end
    end
  end

  // output stage: round to nearest, pick metric, saturate
  logic [RES_W-1:0] rounded;
  logic [RES_W-1:0] picked;
  logic [CMP_W-1:0] wide;

  assign rounded = RES_W'(s_root[ROOT_W][ROOT_W-1:0])
                 + RES_W'(s_rem[ROOT_W] > s_root[ROOT_W]);
  assign picked  = s_euc[ROOT_W] ? rounded : s_lin[ROOT_W];
  assign wide    = CMP_W'(picked);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s_vld[ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    distance <= (wide > CMP_W'(DIST_MAX)) ? DIST_MAX : wide[DIST_W-1:0];
  end

endmodule

// File: rtl/grid_distance_heuristic_core.sv
// grid_distance_heuristic_core: an accepted pair passes the queue, stages a to c, the
// root stages and the output stage before done is high; one pair accepted every cycle,
// set by the root pipeline that resolves one root bit a stage; the receiver
// cannot stall. reset clears the mode to manhattan and empties queue and
// pipeline; busy is high during reset and otherwise only if the queue ever fills.
// depends on gdh_pkg, gdh_front, gdh_queue, gdh_back

module grid_distance_heuristic_core
  import gdh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // command side
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] from_x,
  input  logic [COORD_BITS-1:0] from_y,
  input  logic [COORD_BITS-1:0] to_x,
  input  logic [COORD_BITS-1:0] to_y,
  // distance_mode register
  input  logic                  mode_we,
  input  logic [MODE_W-1:0]     mode_wdata,
  // result side, one beat per accepted pair
  output logic                  done,
  output logic [DIST_W-1:0]     distance
);

  // configured metric
  logic [MODE_W-1:0] mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_MANHATTAN;
    end else if (mode_we) begin
      mode <= mode_wdata;
    end
  end

  // front: abs differences, min and max, operation code
  item_t front_item;

  gdh_front u_front (
    .mode   (mode),
    .from_x (from_x),
    .from_y (from_y),
    .to_x   (to_x),
    .to_y   (to_y),
    .item   (front_item)
  );

  // a beat enters the queue when start meets a free slot
  logic          accept;
  logic          pop;
  item_t         head_item;
  queue_status_t q_status;

  assign busy   = rst | q_status.full;
  assign accept = start & ~busy;
  // the back half never stalls, so the head leaves as soon as it is there
  assign pop    = ~q_status.empty;

  gdh_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_item (front_item),
    .pop       (pop),
    .pop_item  (head_item),
    .status    (q_status)
  );

  // back: squares, radicand, root stages, rounding and saturation
  gdh_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pop),
    .in_item  (head_item),
    .done     (done),
    .distance (distance)
  );

  // the back half drains one beat a cycle, so the queue never fills
  a_never_full : assert property (@(posedge clk) disable iff (rst) !q_status.full)
    else $error("queue filled although the back half never stalls");

  a_status_sane : assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // every accepted pair gives its result beat on done
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##PIPE_LAT done)
    else $error("result beat missing after an accepted pair");

  a_no_spurious : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, PIPE_LAT))
    else $error("result beat without an accepted pair");

endmodule

// File: bench/grid_distance_heuristic_core_tb.sv
// grid_distance_heuristic_core_tb: self-checking bench for the grid distance heuristic core
// drives point pairs under every distance mode, predicts each distance and checks every beat
// depends on gdh_pkg and grid_distance_heuristic_core
`timescale 1ns / 100ps

module grid_distance_heuristic_core_tb;
  import gdh_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int STRAIGHT_STEP = 10;
  localparam int DIAGONAL_STEP = 14;
  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // modes without a metric, all of them give zero
  localparam logic [MODE_W-1:0] MODE_ZERO    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
  localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

  localparam logic [MODE_W-1:0] ALL_MODES [8] = '{
    MODE_MANHATTAN, MODE_EUCLIDEAN, MODE_OCTILE, MODE_CHEBYSHEV,
    MODE_ZERO, MODE_SPARE_A, MODE_SPARE_B, MODE_SPARE_C
  };

  localparam int MAX_REPORTS = 10;

  // one expected distance beat, with the pair and mode that caused it
  typedef struct {
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    logic [MODE_W-1:0]     mode;
    logic [DIST_W-1:0]     distance;
  } distance_beat_t;

  // every input has a known value from time zero
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic [COORD_BITS-1:0] from_x = '0;
  logic [COORD_BITS-1:0] from_y = '0;
  logic [COORD_BITS-1:0] to_x = '0;
  logic [COORD_BITS-1:0] to_y = '0;
  logic                  mode_we = 1'b0;
  logic [MODE_W-1:0]     mode_wdata = '0;
  logic                  busy;
  logic                  done;
  logic [DIST_W-1:0]     distance;

  // bench copy of the distance_mode register
  logic [MODE_W-1:0] active_mode = MODE_MANHATTAN;

  distance_beat_t pending_distances [$];
  int             fail_count = 0;

  grid_distance_heuristic_core u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .from_x     (from_x),
    .from_y     (from_y),
    .to_x       (to_x),
    .to_y       (to_y),
    .mode_we    (mode_we),
    .mode_wdata (mode_wdata),
    .done       (done),
    .distance   (distance)
  );

  always #(CLK_HALF) clk = ~clk;

  // generous ceiling, far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("== FAIL ==");
    $finish;
  end

  // nearest integer root; n is an integer so the root never sits exactly halfway
  function automatic longint unsigned rounded_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    // remainder past root + 1/2 rounds up
    if (n - root * root > root) root = root + 1;
    return root;
  endfunction

  // distance the core should give for one pair under one mode
  function automatic logic [DIST_W-1:0] heuristic_distance(
    input logic [MODE_W-1:0]     mode,
    input logic [COORD_BITS-1:0] fx,
    input logic [COORD_BITS-1:0] fy,
    input logic [COORD_BITS-1:0] tx,
    input logic [COORD_BITS-1:0] ty
  );
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned d;
    dx = (fx > tx) ? 64'(fx - tx) : 64'(tx - fx);
    dy = (fy > ty) ? 64'(fy - ty) : 64'(ty - fy);
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    case (mode)
      MODE_MANHATTAN: d = STRAIGHT_STEP * (dx + dy);
      MODE_EUCLIDEAN: d = rounded_root(STRAIGHT_STEP * STRAIGHT_STEP * (dx * dx + dy * dy));
      MODE_OCTILE:    d = DIAGONAL_STEP * lo + STRAIGHT_STEP * (hi - lo);
      MODE_CHEBYSHEV: d = STRAIGHT_STEP * hi;
      default:        d = 0;
    endcase
    // saturation only bites with wider coordinates
    if (d > DIST_MAX) d = 64'(DIST_MAX);
    return d[DIST_W-1:0];
  endfunction

  // result checker: done is a one-cycle strobe, the receiver never stalls
  always @(posedge clk) begin : check_distances
    distance_beat_t want;
    if (!rst && done === 1'b1) begin
      if (pending_distances.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: unexpected distance beat %0d, nothing outstanding", $time, distance);
      end else begin
        want = pending_distances.pop_front();
        if (distance !== want.distance) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: mode %0d (%0d,%0d)->(%0d,%0d) distance exp %0d got %0d",
                     $time, want.mode, want.fx, want.fy, want.tx, want.ty,
                     want.distance, distance);
        end
      end
    end
  end

  // hold until every beat already predicted has come back
  task automatic wait_drained();
    while (pending_distances.size() != 0) @(posedge clk);
  endtask

  // mode register is only touched with the core empty
  task automatic change_mode(input logic [MODE_W-1:0] mode);
    start <= 1'b0;
    wait_drained();
    mode_we    <= 1'b1;
    mode_wdata <= mode;
    @(posedge clk);
    mode_we     <= 1'b0;
    active_mode  = mode;
  endtask

  // one pair; start is left high so the next beat can follow back to back
  task automatic send_pair(
    input logic [COORD_BITS-1:0] fx,
    input logic [COORD_BITS-1:0] fy,
    input logic [COORD_BITS-1:0] tx,
    input logic [COORD_BITS-1:0] ty
  );
    distance_beat_t beat;
    from_x <= fx;
    from_y <= fy;
    to_x   <= tx;
    to_y   <= ty;
    start  <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    beat.fx       = fx;
    beat.fy       = fy;
    beat.tx       = tx;
    beat.ty       = ty;
    beat.mode     = active_mode;
    beat.distance = heuristic_distance(active_mode, fx, fy, tx, ty);
    pending_distances.push_back(beat);
  endtask

  // sender idles cycle by cycle with the given chance in a hundred
  task automatic sender_gap(input int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // random pair in one of several shapes, biased towards interesting geometry
  task automatic send_random_pair();
    logic [COORD_BITS-1:0] fx;
    logic [COORD_BITS-1:0] fy;
    logic [COORD_BITS-1:0] tx;
    logic [COORD_BITS-1:0] ty;
    int unsigned           span;
    fx = COORD_BITS'($urandom_range(COORD_MAX));
    fy = COORD_BITS'($urandom_range(COORD_MAX));
    tx = COORD_BITS'($urandom_range(COORD_MAX));
    ty = COORD_BITS'($urandom_range(COORD_MAX));
    case ($urandom_range(9))
      5, 6: begin
        // close neighbours, small differences where rounding is finest
        tx = fx ^ COORD_BITS'($urandom_range(15));
        ty = fy ^ COORD_BITS'($urandom_range(15));
      end
      7: begin
        // corners of the grid
        fx = {COORD_BITS{1'($urandom_range(1))}};
        fy = {COORD_BITS{1'($urandom_range(1))}};
        tx = {COORD_BITS{1'($urandom_range(1))}};
        ty = {COORD_BITS{1'($urandom_range(1))}};
      end
      8: begin
        // pure diagonal, dx equal to dy
        span = $urandom_range(COORD_MAX);
        fx = COORD_BITS'($urandom_range(COORD_MAX - span));
        fy = COORD_BITS'($urandom_range(COORD_MAX - span));
        tx = fx + COORD_BITS'(span);
        ty = fy + COORD_BITS'(span);
        if ($urandom_range(1)) begin
          fx = tx - COORD_BITS'(span);
          tx = fx;
          fx = tx + COORD_BITS'(span);
        end
      end
      9: begin
        // same point
        tx = fx;
        ty = fy;
      end
      default: ;
    endcase
    send_pair(fx, fy, tx, ty);
  endtask

  // runs of random pairs, each run under a fresh mode; metric modes dominate
  task automatic run_random_phase(input int n_items, input int idle_pct);
    int sent;
    int run_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(11) < 10) change_mode(ALL_MODES[$urandom_range(3)]);
      else change_mode(ALL_MODES[$urandom_range(7, 4)]);
      run_len = $urandom_range(40, 8);
      for (int i = 0; i < run_len && sent < n_items; i++) begin
        send_random_pair();
        sender_gap(idle_pct);
        sent++;
      end
    end
    start <= 1'b0;
  endtask

  // extremes, rounding cases and every mode code, reset mode first unwritten
  task automatic test_directed_cases();
    // reset value of the mode register is manhattan
    send_pair('0, '0, '0, '0);
    send_pair(COORD_MAX, COORD_MAX, '0, '0);
    send_pair('0, COORD_MAX, COORD_MAX, '0);
    change_mode(MODE_EUCLIDEAN);
    send_pair(COORD_MAX, COORD_MAX, '0, '0);
    send_pair('0, '0, 10'd3, 10'd4);
    send_pair('0, '0, 10'd1, 10'd1);
    send_pair('0, '0, 10'd1, 10'd2);
    // root just past the half, rounds up
    send_pair('0, '0, 10'd1, 10'd3);
    change_mode(MODE_OCTILE);
    send_pair(COORD_MAX, '0, '0, COORD_MAX);
    send_pair('0, '0, COORD_MAX, 10'd5);
    send_pair(10'd5, COORD_MAX, '0, '0);
    change_mode(MODE_CHEBYSHEV);
    send_pair('0, '0, COORD_MAX, 10'd1);
    send_pair(10'd512, 10'd511, 10'd511, 10'd512);
    // the zero mode and the spare codes behave alike
    change_mode(MODE_ZERO);
    send_pair(COORD_MAX, COORD_MAX, '0, '0);
    change_mode(MODE_SPARE_A);
    send_pair(COORD_MAX, '0, '0, COORD_MAX);
    change_mode(MODE_SPARE_B);
    send_pair('0, COORD_MAX, COORD_MAX, '0);
    change_mode(MODE_SPARE_C);
    send_pair(COORD_MAX, COORD_MAX, '0, '0);
    // back to the lowest code written explicitly
    change_mode(MODE_MANHATTAN);
    send_pair(COORD_MAX, '0, '0, COORD_MAX);
    start <= 1'b0;
  endtask

  // sender mostly present
  task automatic test_light_sender_gaps();
    run_random_phase(283, 28);
  endtask

  // sender mostly absent
  task automatic test_heavy_sender_gaps();
    run_random_phase(283, 64);
  endtask

  // full rate, one pair every cycle within each run between mode changes
  task automatic test_back_to_back();
    run_random_phase(284, 0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_light_sender_gaps();
    test_heavy_sender_gaps();
    test_back_to_back();
    start <= 1'b0;
    wait_drained();
    // catch any stray beat still in the pipeline
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (fail_count == 0 && pending_distances.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
